[rtl/ssd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and helpers for the segment-segment distance unit.
// No dependencies.
package ssd_pkg;

    localparam int CW           = 24;
    localparam int DW           = 2 * CW + 1;
    localparam int PW           = 2 * CW + 2;
    localparam int SW           = 2 * CW + 3;
    localparam int DIST_W       = 50;
    localparam int CFG_W        = 16;
    localparam int NPT          = 4;
    localparam int NCAND        = 4;
    localparam int NDIV         = 2 * NCAND + 2;
    localparam int DIV_CX       = 2 * NCAND;
    localparam int DIV_CY       = 2 * NCAND + 1;
    localparam int FRONT_STAGES = 4;
    localparam int BACK_STAGES  = 5;
    localparam int LATENCY      = FRONT_STAGES + CW + BACK_STAGES;

    // candidate c projects point CAND_P onto segment CAND_S..CAND_E
    localparam int CAND_P [NCAND] = '{2, 3, 0, 1};
    localparam int CAND_S [NCAND] = '{0, 0, 2, 2};
    localparam int CAND_E [NCAND] = '{1, 1, 3, 3};

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [CW:0]   diff_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [SW-1:0] sum_t;
    typedef logic [DIST_W-1:0]    dist_t;

    typedef enum logic [1:0] {
        FOOT_START,
        FOOT_END,
        FOOT_DIV
    } foot_mode_t;

    typedef struct packed {
        logic [DW-1:0] num;
        logic [DW-1:0] den;
        logic [CW-1:0] mag;
    } div_op_t;

    typedef struct packed {
        foot_mode_t mode;
        logic       neg_x;
        logic       neg_y;
        coord_t     p_x;
        coord_t     p_y;
        coord_t     s_x;
        coord_t     s_y;
        coord_t     e_x;
        coord_t     e_y;
    } cand_side_t;

    typedef struct packed {
        cand_side_t [NCAND-1:0] cand;
        logic                   a_pt;
        logic                   b_pt;
        logic                   cross_hit;
        logic                   cross_neg_x;
        logic                   cross_neg_y;
        dist_t                  pp_dist;
    } side_t;

    typedef struct packed {
        logic                   a_pt;
        logic                   b_pt;
        logic                   hit;
        dist_t                  pp_dist;
        coord_t                 cross_x;
        coord_t                 cross_y;
        coord_t [NCAND-1:0]     q_x;
        coord_t [NCAND-1:0]     q_y;
    } back_ctl_t;

    function automatic logic [CW-1:0] mag_of(diff_t v);
        diff_t a;
        a = v[CW] ? -v : v;
        return a[CW-1:0];
    endfunction

    function automatic coord_t step_foot(coord_t s, coord_t e, foot_mode_t m, logic neg,
                                         logic [CW-1:0] q);
        diff_t t;
        case (m)
            FOOT_START: t = diff_t'(s);
            FOOT_END:   t = diff_t'(e);
            default:    t = neg ? diff_t'(s) - diff_t'({1'b0, q})
                                : diff_t'(s) + diff_t'({1'b0, q});
        endcase
        return coord_t'(t[CW-1:0]);
    endfunction

endpackage

[rtl/ssd_delay.sv]
`timescale 1ns / 1ps
// Fixed-depth delay line with valid bit, carries sideband alongside the dividers.
// No dependencies.
module ssd_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    logic             vld_reg  [DEPTH];
    logic [WIDTH-1:0] data_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            data_reg[0] <= in_data;
        for (int i = 1; i < DEPTH; i++)
            if (vld_reg[i-1])
                data_reg[i] <= data_reg[i-1];
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

[rtl/ssd_muldiv.sv]
`timescale 1ns / 1ps
// Pipelined floor(num*mag/den) for num <= den, one multiplier bit per stage.
// Depends on ssd_pkg.
module ssd_muldiv
    import ssd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  div_op_t       op,
    output logic [CW-1:0] quot
);

    localparam int RW = DW + 2;

    logic          vld_reg [CW];
    logic [RW-1:0] rem_reg [CW];
    logic [CW-1:0] quo_reg [CW];
    logic [CW-1:0] mag_reg [CW];
    logic [DW-1:0] num_reg [CW];
    logic [DW-1:0] den_reg [CW];

    for (genvar k = 0; k < CW; k++)
    begin : g_step
        logic          v_in;
        logic [RW-1:0] r_in;
        logic [RW-1:0] t;
        logic [RW-1:0] den1;
        logic [RW-1:0] den2;
        logic [RW-1:0] r_next;
        logic [CW-1:0] q_in;
        logic [CW-1:0] q_next;
        logic [CW-1:0] m_in;
        logic [DW-1:0] n_in;
        logic [DW-1:0] d_in;
        logic [1:0]    dig;

        if (k == 0)
        begin : g_first
            assign v_in = in_valid;
            assign r_in = '0;
            assign q_in = '0;
            assign m_in = op.mag;
            assign n_in = op.num;
            assign d_in = op.den;
        end
        else
        begin : g_next
            assign v_in = vld_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign q_in = quo_reg[k-1];
            assign m_in = mag_reg[k-1];
            assign n_in = num_reg[k-1];
            assign d_in = den_reg[k-1];
        end

        assign den1 = {2'b00, d_in};
        assign den2 = {1'b0, d_in, 1'b0};
        assign t    = {r_in[RW-2:0], 1'b0} + (m_in[CW-1-k] ? {2'b00, n_in} : RW'(0));

        always_comb
        begin
            if (t >= den2)
            begin
                r_next = t - den2;
                dig    = 2'd2;
            end
            else if (t >= den1)
            begin
                r_next = t - den1;
                dig    = 2'd1;
            end
            else
            begin
                r_next = t;
                dig    = 2'd0;
            end
            q_next = {q_in[CW-2:0], 1'b0} + CW'(dig);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (v_in)
            begin
                rem_reg[k] <= r_next;
                quo_reg[k] <= q_next;
                mag_reg[k] <= m_in;
                num_reg[k] <= n_in;
                den_reg[k] <= d_in;
            end
        end
    end

    assign quot = quo_reg[CW-1];

endmodule

[rtl/ssd_front.sv]
`timescale 1ns / 1ps
// Front pipeline: differences, products, dot/cross sums, case classification.
// Depends on ssd_pkg.
module ssd_front
    import ssd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  coord_t                 a_start_x,
    input  coord_t                 a_start_y,
    input  coord_t                 a_end_x,
    input  coord_t                 a_end_y,
    input  coord_t                 b_start_x,
    input  coord_t                 b_start_y,
    input  coord_t                 b_end_x,
    input  coord_t                 b_end_y,
    input  logic [CFG_W-1:0]       deg_len,
    output logic                   out_valid,
    output div_op_t [NDIV-1:0]     div_op,
    output side_t                  side
);

    coord_t in_x [NPT];
    coord_t in_y [NPT];

    assign in_x[0] = a_start_x;
    assign in_y[0] = a_start_y;
    assign in_x[1] = a_end_x;
    assign in_y[1] = a_end_y;
    assign in_x[2] = b_start_x;
    assign in_y[2] = b_start_y;
    assign in_x[3] = b_end_x;
    assign in_y[3] = b_end_y;

    logic [FRONT_STAGES-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
    end

    // stage 1: differences
    coord_t pt1_x_reg [NPT];
    coord_t pt1_y_reg [NPT];
    diff_t  px1_reg [NCAND];
    diff_t  py1_reg [NCAND];
    diff_t  dx1_reg [NCAND];
    diff_t  dy1_reg [NCAND];
    diff_t  wx1_reg;
    diff_t  wy1_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            for (int i = 0; i < NPT; i++)
            begin
                pt1_x_reg[i] <= in_x[i];
                pt1_y_reg[i] <= in_y[i];
            end
            for (int c = 0; c < NCAND; c++)
            begin
                px1_reg[c] <= diff_t'(in_x[CAND_P[c]]) - diff_t'(in_x[CAND_S[c]]);
                py1_reg[c] <= diff_t'(in_y[CAND_P[c]]) - diff_t'(in_y[CAND_S[c]]);
                dx1_reg[c] <= diff_t'(in_x[CAND_E[c]]) - diff_t'(in_x[CAND_S[c]]);
                dy1_reg[c] <= diff_t'(in_y[CAND_E[c]]) - diff_t'(in_y[CAND_S[c]]);
            end
            wx1_reg <= diff_t'(in_x[3]) - diff_t'(in_x[1]);
            wy1_reg <= diff_t'(in_y[3]) - diff_t'(in_y[1]);
        end
    end

    // stage 2: products
    coord_t pt2_x_reg [NPT];
    coord_t pt2_y_reg [NPT];
    diff_t  dx2_reg [NCAND];
    diff_t  dy2_reg [NCAND];
    prod_t  denx2_reg [NCAND];
    prod_t  deny2_reg [NCAND];
    prod_t  numx2_reg [NCAND];
    prod_t  numy2_reg [NCAND];
    prod_t  m2_reg [6];
    prod_t  ppx2_reg;
    prod_t  ppy2_reg;

    always_ff @(posedge clk)
    begin
        if (vld_reg[0])
        begin
            pt2_x_reg <= pt1_x_reg;
            pt2_y_reg <= pt1_y_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            for (int c = 0; c < NCAND; c++)
            begin
                denx2_reg[c] <= prod_t'(dx1_reg[c]) * prod_t'(dx1_reg[c]);
                deny2_reg[c] <= prod_t'(dy1_reg[c]) * prod_t'(dy1_reg[c]);
                numx2_reg[c] <= prod_t'(px1_reg[c]) * prod_t'(dx1_reg[c]);
                numy2_reg[c] <= prod_t'(py1_reg[c]) * prod_t'(dy1_reg[c]);
            end
            m2_reg[0] <= prod_t'(dy1_reg[0]) * prod_t'(dx1_reg[2]);
            m2_reg[1] <= prod_t'(dy1_reg[2]) * prod_t'(dx1_reg[0]);
            m2_reg[2] <= prod_t'(dy1_reg[2]) * prod_t'(wx1_reg);
            m2_reg[3] <= prod_t'(wy1_reg) * prod_t'(dx1_reg[2]);
            m2_reg[4] <= prod_t'(dy1_reg[0]) * prod_t'(wx1_reg);
            m2_reg[5] <= prod_t'(wy1_reg) * prod_t'(dx1_reg[0]);
            ppx2_reg  <= prod_t'(px1_reg[2]) * prod_t'(px1_reg[2]);
            ppy2_reg  <= prod_t'(py1_reg[2]) * prod_t'(py1_reg[2]);
        end
    end

    // stage 3: sums
    coord_t pt3_x_reg [NPT];
    coord_t pt3_y_reg [NPT];
    diff_t  dx3_reg [NCAND];
    diff_t  dy3_reg [NCAND];
    sum_t   den3_reg [NCAND];
    sum_t   num3_reg [NCAND];
    sum_t   d3_reg;
    sum_t   nt3_reg;
    sum_t   ns3_reg;
    sum_t   pp3_reg;

    always_ff @(posedge clk)
    begin
        if (vld_reg[1])
        begin
            pt3_x_reg <= pt2_x_reg;
            pt3_y_reg <= pt2_y_reg;
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
            for (int c = 0; c < NCAND; c++)
            begin
                den3_reg[c] <= sum_t'(denx2_reg[c]) + sum_t'(deny2_reg[c]);
                num3_reg[c] <= sum_t'(numx2_reg[c]) + sum_t'(numy2_reg[c]);
            end
            d3_reg  <= sum_t'(m2_reg[0]) - sum_t'(m2_reg[1]);
            nt3_reg <= sum_t'(m2_reg[2]) - sum_t'(m2_reg[3]);
            ns3_reg <= sum_t'(m2_reg[4]) - sum_t'(m2_reg[5]);
            pp3_reg <= sum_t'(ppx2_reg) + sum_t'(ppy2_reg);
        end
    end

    // stage 4: classification and divider operands
    side_t               side_next;
    div_op_t [NDIV-1:0]  div_next;
    side_t               side_reg;
    div_op_t [NDIV-1:0]  div_reg;

    always_comb
    begin
        sum_t d_abs;
        sum_t nt_abs;
        sum_t ns_abs;
        sum_t lim;
        lim = sum_t'({1'b0, deg_len});
        if (d3_reg[SW-1])
        begin
            d_abs  = -d3_reg;
            nt_abs = -nt3_reg;
            ns_abs = -ns3_reg;
        end
        else
        begin
            d_abs  = d3_reg;
            nt_abs = nt3_reg;
            ns_abs = ns3_reg;
        end
        side_next.a_pt        = den3_reg[0] <= lim;
        side_next.b_pt        = den3_reg[2] <= lim;
        side_next.cross_hit   = (d3_reg != '0) && !nt_abs[SW-1] && (nt_abs <= d_abs)
                                && !ns_abs[SW-1] && (ns_abs <= d_abs);
        side_next.cross_neg_x = !dx3_reg[0][CW] && (dx3_reg[0] != '0);
        side_next.cross_neg_y = !dy3_reg[0][CW] && (dy3_reg[0] != '0);
        side_next.pp_dist     = pp3_reg[DIST_W-1:0];
        for (int c = 0; c < NCAND; c++)
        begin
            side_next.cand[c].p_x   = pt3_x_reg[CAND_P[c]];
            side_next.cand[c].p_y   = pt3_y_reg[CAND_P[c]];
            side_next.cand[c].s_x   = pt3_x_reg[CAND_S[c]];
            side_next.cand[c].s_y   = pt3_y_reg[CAND_S[c]];
            side_next.cand[c].e_x   = pt3_x_reg[CAND_E[c]];
            side_next.cand[c].e_y   = pt3_y_reg[CAND_E[c]];
            side_next.cand[c].neg_x = dx3_reg[c][CW];
            side_next.cand[c].neg_y = dy3_reg[c][CW];
            if ((den3_reg[c] == '0) || num3_reg[c][SW-1] || (num3_reg[c] == '0))
                side_next.cand[c].mode = FOOT_START;
            else if (num3_reg[c] >= den3_reg[c])
                side_next.cand[c].mode = FOOT_END;
            else
                side_next.cand[c].mode = FOOT_DIV;
            div_next[2*c].num   = num3_reg[c][DW-1:0];
            div_next[2*c].den   = den3_reg[c][DW-1:0];
            div_next[2*c].mag   = mag_of(dx3_reg[c]);
            div_next[2*c+1].num = num3_reg[c][DW-1:0];
            div_next[2*c+1].den = den3_reg[c][DW-1:0];
            div_next[2*c+1].mag = mag_of(dy3_reg[c]);
        end
        div_next[DIV_CX].num = nt_abs[DW-1:0];
        div_next[DIV_CX].den = d_abs[DW-1:0];
        div_next[DIV_CX].mag = mag_of(dx3_reg[0]);
        div_next[DIV_CY].num = nt_abs[DW-1:0];
        div_next[DIV_CY].den = d_abs[DW-1:0];
        div_next[DIV_CY].mag = mag_of(dy3_reg[0]);
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[2])
        begin
            side_reg <= side_next;
            div_reg  <= div_next;
        end
    end

    assign out_valid = vld_reg[FRONT_STAGES-1];
    assign side      = side_reg;
    assign div_op    = div_reg;

    a_cross_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && side.cross_hit |-> div_op[DIV_CX].num <= div_op[DIV_CX].den)
        else $error("crossing numerator exceeds denominator");

    a_proj_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (side.cand[0].mode == FOOT_DIV) |-> div_op[0].num < div_op[0].den)
        else $error("projection sent to divider outside open interval");

endmodule

[rtl/ssd_back.sv]
`timescale 1ns / 1ps
// Back pipeline: feet, squared distances, candidate selection, result registers.
// Depends on ssd_pkg.
module ssd_back
    import ssd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  side_t                    side,
    input  logic [NDIV-1:0][CW-1:0]  quot,
    output logic                     done,
    output dist_t                    dist_sq,
    output coord_t                   closest_x,
    output coord_t                   closest_y
);

    logic [BACK_STAGES-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[BACK_STAGES-2:0], in_valid};
    end

    // stage 1: feet and offsets
    back_ctl_t ctl_next;
    diff_t     ex_next [NCAND];
    diff_t     ey_next [NCAND];
    back_ctl_t ctl1_reg;
    diff_t     ex1_reg [NCAND];
    diff_t     ey1_reg [NCAND];

    always_comb
    begin
        coord_t fx;
        coord_t fy;
        ctl_next.a_pt    = side.a_pt;
        ctl_next.b_pt    = side.b_pt;
        ctl_next.hit     = side.cross_hit;
        ctl_next.pp_dist = side.pp_dist;
        ctl_next.cross_x = step_foot(side.cand[0].e_x, side.cand[0].e_x, FOOT_DIV,
                                     side.cross_neg_x, quot[DIV_CX]);
        ctl_next.cross_y = step_foot(side.cand[0].e_y, side.cand[0].e_y, FOOT_DIV,
                                     side.cross_neg_y, quot[DIV_CY]);
        for (int c = 0; c < NCAND; c++)
        begin
            fx = step_foot(side.cand[c].s_x, side.cand[c].e_x, side.cand[c].mode,
                           side.cand[c].neg_x, quot[2*c]);
            fy = step_foot(side.cand[c].s_y, side.cand[c].e_y, side.cand[c].mode,
                           side.cand[c].neg_y, quot[2*c+1]);
            ex_next[c] = diff_t'(side.cand[c].p_x) - diff_t'(fx);
            ey_next[c] = diff_t'(side.cand[c].p_y) - diff_t'(fy);
            // endpoints of B onto A report the foot, endpoints of A report themselves
            ctl_next.q_x[c] = (c < 2) ? fx : side.cand[c].p_x;
            ctl_next.q_y[c] = (c < 2) ? fy : side.cand[c].p_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            ctl1_reg <= ctl_next;
            ex1_reg  <= ex_next;
            ey1_reg  <= ey_next;
        end
    end

    // stage 2: squares
    back_ctl_t ctl2_reg;
    prod_t     sx2_reg [NCAND];
    prod_t     sy2_reg [NCAND];

    always_ff @(posedge clk)
    begin
        if (vld_reg[0])
        begin
            ctl2_reg <= ctl1_reg;
            for (int c = 0; c < NCAND; c++)
            begin
                sx2_reg[c] <= prod_t'(ex1_reg[c]) * prod_t'(ex1_reg[c]);
                sy2_reg[c] <= prod_t'(ey1_reg[c]) * prod_t'(ey1_reg[c]);
            end
        end
    end

    // stage 3: distances
    back_ctl_t ctl3_reg;
    dist_t     dist3_reg [NCAND];
    sum_t      dsum [NCAND];

    always_comb
    begin
        for (int c = 0; c < NCAND; c++)
            dsum[c] = sum_t'(sx2_reg[c]) + sum_t'(sy2_reg[c]);
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[1])
        begin
            ctl3_reg <= ctl2_reg;
            for (int c = 0; c < NCAND; c++)
                dist3_reg[c] <= dsum[c][DIST_W-1:0];
        end
    end

    // stage 4: pairwise minimum, earlier wins a tie
    back_ctl_t ctl4_reg;
    dist_t     d0_4_reg;
    dist_t     d2_4_reg;
    dist_t     da4_reg;
    dist_t     db4_reg;
    coord_t    qax4_reg;
    coord_t    qay4_reg;
    coord_t    qbx4_reg;
    coord_t    qby4_reg;

    always_ff @(posedge clk)
    begin
        if (vld_reg[2])
        begin
            ctl4_reg <= ctl3_reg;
            d0_4_reg <= dist3_reg[0];
            d2_4_reg <= dist3_reg[2];
            if (dist3_reg[1] < dist3_reg[0])
            begin
                da4_reg  <= dist3_reg[1];
                qax4_reg <= ctl3_reg.q_x[1];
                qay4_reg <= ctl3_reg.q_y[1];
            end
            else
            begin
                da4_reg  <= dist3_reg[0];
                qax4_reg <= ctl3_reg.q_x[0];
                qay4_reg <= ctl3_reg.q_y[0];
            end
            if (dist3_reg[3] < dist3_reg[2])
            begin
                db4_reg  <= dist3_reg[3];
                qbx4_reg <= ctl3_reg.q_x[3];
                qby4_reg <= ctl3_reg.q_y[3];
            end
            else
            begin
                db4_reg  <= dist3_reg[2];
                qbx4_reg <= ctl3_reg.q_x[2];
                qby4_reg <= ctl3_reg.q_y[2];
            end
        end
    end

    // stage 5: case select
    dist_t  dist_next;
    coord_t qx_next;
    coord_t qy_next;
    dist_t  dist_reg;
    coord_t qx_reg;
    coord_t qy_reg;

    always_comb
    begin
        if (ctl4_reg.a_pt)
        begin
            dist_next = ctl4_reg.b_pt ? ctl4_reg.pp_dist : d2_4_reg;
            qx_next   = ctl4_reg.q_x[2];
            qy_next   = ctl4_reg.q_y[2];
        end
        else if (ctl4_reg.b_pt)
        begin
            dist_next = d0_4_reg;
            qx_next   = ctl4_reg.q_x[0];
            qy_next   = ctl4_reg.q_y[0];
        end
        else if (ctl4_reg.hit)
        begin
            dist_next = '0;
            qx_next   = ctl4_reg.cross_x;
            qy_next   = ctl4_reg.cross_y;
        end
        else if (db4_reg < da4_reg)
        begin
            dist_next = db4_reg;
            qx_next   = qbx4_reg;
            qy_next   = qby4_reg;
        end
        else
        begin
            dist_next = da4_reg;
            qx_next   = qax4_reg;
            qy_next   = qay4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[3])
        begin
            dist_reg <= dist_next;
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
        end
    end

    assign done      = vld_reg[BACK_STAGES-1];
    assign dist_sq   = dist_reg;
    assign closest_x = qx_reg;
    assign closest_y = qy_reg;

endmodule

[rtl/segment_segment_distance_squared_unit.sv]
`timescale 1ns / 1ps
// Top level of the segment-segment squared distance unit.
// Depends on ssd_pkg, ssd_front, ssd_muldiv, ssd_delay, ssd_back.

// One segment pair is taken on every clock at which start is high; busy never
// rises. Each pair returns one beat on done after passing through 4 front
// stages (differences, products, sums, classification), 24 stages of the
// pipelined multiply-divide units, one per coordinate bit, and 5 back stages
// (feet, squares, sums, pairwise minimum, case select). Results are not held:
// the receiver must take each beat in the cycle that done is high. Write
// degenerate_len_sq through cfg_wr_en/cfg_wr_data only while no pair is in flight.
module segment_segment_distance_squared_unit
    import ssd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  coord_t            a_start_x,
    input  coord_t            a_start_y,
    input  coord_t            a_end_x,
    input  coord_t            a_end_y,
    input  coord_t            b_start_x,
    input  coord_t            b_start_y,
    input  coord_t            b_end_x,
    input  coord_t            b_end_y,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    output logic              done,
    output dist_t             dist_sq,
    output coord_t            closest_x,
    output coord_t            closest_y
);

    logic [CFG_W-1:0] deg_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deg_len_reg <= '0;
        else if (cfg_wr_en)
            deg_len_reg <= cfg_wr_data;
    end

    assign busy = 1'b0;

    logic                   front_valid;
    div_op_t [NDIV-1:0]     div_op;
    side_t                  side_f;
    logic [$bits(side_t)-1:0] side_bits_d;
    side_t                  side_d;
    logic                   side_valid;
    logic [NDIV-1:0][CW-1:0] quot;

    ssd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .a_start_x (a_start_x),
        .a_start_y (a_start_y),
        .a_end_x   (a_end_x),
        .a_end_y   (a_end_y),
        .b_start_x (b_start_x),
        .b_start_y (b_start_y),
        .b_end_x   (b_end_x),
        .b_end_y   (b_end_y),
        .deg_len   (deg_len_reg),
        .out_valid (front_valid),
        .div_op    (div_op),
        .side      (side_f)
    );

    for (genvar i = 0; i < NDIV; i++)
    begin : g_div
        ssd_muldiv u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (front_valid),
            .op       (div_op[i]),
            .quot     (quot[i])
        );
    end

    ssd_delay #(
        .WIDTH ($bits(side_t)),
        .DEPTH (CW)
    ) u_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_data   (side_f),
        .out_valid (side_valid),
        .out_data  (side_bits_d)
    );

    assign side_d = side_t'(side_bits_d);

    ssd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (side_valid),
        .side      (side_d),
        .quot      (quot),
        .done      (done),
        .dist_sq   (dist_sq),
        .closest_x (closest_x),
        .closest_y (closest_y)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result beat without a matching start");

    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> dist_sq[DIST_W-1:2*CW+1] == '0)
        else $error("squared distance beyond coordinate range");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for segment_segment_distance_squared_unit: directed table then random pairs,
// each result checked against a known value or a built-in closest-distance predictor.
// Depends on ssd_pkg and the RTL of the unit.
module tb_top;
    import ssd_pkg::*;

    typedef struct {
        coord_t c[8];
    } seg_pair_t;

    typedef struct {
        dist_t  d;
        coord_t x;
        coord_t y;
    } closest_t;

    typedef struct {
        logic     cfg;
        logic [CFG_W-1:0] cfg_val;
        seg_pair_t p;
        logic     known;
        closest_t r;
    } dir_row_t;

    logic clk, rst_n, start, busy, cfg_wr_en, done;
    logic [CFG_W-1:0] cfg_wr_data;
    coord_t in_c[8];
    dist_t dist_sq;
    coord_t closest_x, closest_y;

    logic [CFG_W-1:0] deg_len_sq;
    closest_t expected_q[$];
    int errors;
    longint cycles;
    int send_idle;

    segment_segment_distance_squared_unit i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .a_start_x(in_c[0]), .a_start_y(in_c[1]), .a_end_x(in_c[2]), .a_end_y(in_c[3]),
        .b_start_x(in_c[4]), .b_start_y(in_c[5]), .b_end_x(in_c[6]), .b_end_y(in_c[7]),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .done(done), .dist_sq(dist_sq), .closest_x(closest_x), .closest_y(closest_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // base +/- floor(num*|delta|/den), exact at 128 bits
    function automatic longint trunc_scale(longint base, longint delta, longint num,
                                           longint den);
        logic [127:0] prod;
        logic [127:0] part;
        longint mag;
        mag = delta < 0 ? -delta : delta;
        prod = 128'(num) * 128'(mag);
        part = prod / 128'(den);
        return delta < 0 ? base - longint'(part) : base + longint'(part);
    endfunction

    function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
        return (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
    endfunction

    function automatic longint project(longint px, longint py, longint sx, longint sy,
                                       longint ex, longint ey,
                                       output longint fx, output longint fy);
        longint dx, dy, den, num;
        dx = ex - sx;
        dy = ey - sy;
        den = dx * dx + dy * dy;
        num = (px - sx) * dx + (py - sy) * dy;
        if (den == 0 || num <= 0)
        begin
            fx = sx;
            fy = sy;
        end
        else if (num >= den)
        begin
            fx = ex;
            fy = ey;
        end
        else
        begin
            fx = trunc_scale(sx, dx, num, den);
            fy = trunc_scale(sy, dy, num, den);
        end
        return sq_dist(px, py, fx, fy);
    endfunction

    function automatic closest_t closest_between(seg_pair_t p);
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint l12, l34, best_dist, cand, qx, qy, tx, ty, d, nt, ns;
        logic crossed;
        closest_t r;
        x1 = p.c[0]; y1 = p.c[1]; x2 = p.c[2]; y2 = p.c[3];
        x3 = p.c[4]; y3 = p.c[5]; x4 = p.c[6]; y4 = p.c[7];
        l12 = sq_dist(x1, y1, x2, y2);
        l34 = sq_dist(x3, y3, x4, y4);
        crossed = 1'b0;
        if (l12 <= longint'(deg_len_sq))
        begin
            qx = x1;
            qy = y1;
            if (l34 <= longint'(deg_len_sq))
                best_dist = sq_dist(x1, y1, x3, y3);
            else
                best_dist = project(x1, y1, x3, y3, x4, y4, tx, ty);
        end
        else if (l34 <= longint'(deg_len_sq))
            best_dist = project(x3, y3, x1, y1, x2, y2, qx, qy);
        else
        begin
            d = (y4 - y3) * (x1 - x2) - (y1 - y2) * (x4 - x3);
            if (d != 0)
            begin
                nt = (y4 - y3) * (x4 - x2) - (y4 - y2) * (x4 - x3);
                ns = (y4 - y2) * (x1 - x2) - (y1 - y2) * (x4 - x2);
                if (d < 0)
                begin
                    d = -d;
                    nt = -nt;
                    ns = -ns;
                end
                if (nt >= 0 && nt <= d && ns >= 0 && ns <= d)
                begin
                    crossed = 1'b1;
                    qx = trunc_scale(x2, x1 - x2, nt, d);
                    qy = trunc_scale(y2, y1 - y2, nt, d);
                    best_dist = 0;
                end
            end
            if (!crossed)
            begin
                best_dist = project(x3, y3, x1, y1, x2, y2, qx, qy);
                cand = project(x4, y4, x1, y1, x2, y2, tx, ty);
                if (cand < best_dist)
                begin
                    best_dist = cand; qx = tx; qy = ty;
                end
                cand = project(x1, y1, x3, y3, x4, y4, tx, ty);
                if (cand < best_dist)
                begin
                    best_dist = cand; qx = x1; qy = y1;
                end
                cand = project(x2, y2, x3, y3, x4, y4, tx, ty);
                if (cand < best_dist)
                begin
                    best_dist = cand; qx = x2; qy = y2;
                end
            end
        end
        r.d = dist_t'(best_dist);
        r.x = coord_t'(qx);
        r.y = coord_t'(qy);
        return r;
    endfunction

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 64) - 32);
            2: return coord_t'($urandom_range(0, 8192) - 4096);
            default: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
        endcase
    endfunction

    function automatic seg_pair_t rand_pair();
        seg_pair_t p;
        int mode, k;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 8; i++)
        begin
            k = mode < 3 ? 0 : (mode < 6 ? 1 : (mode < 9 ? 2 : $urandom_range(0, 3)));
            p.c[i] = rand_coord(k);
        end
        // occasional degenerate, shared-endpoint or parallel shapes
        case ($urandom_range(0, 7))
            0: begin p.c[2] = p.c[0] + coord_t'($urandom_range(0, 2)); p.c[3] = p.c[1]; end
            1: begin p.c[6] = p.c[4]; p.c[7] = p.c[5] + coord_t'($urandom_range(0, 2)); end
            2: begin p.c[4] = p.c[2]; p.c[5] = p.c[3]; end
            3:
            begin
                p.c[4] = p.c[0] + coord_t'(3); p.c[5] = p.c[1] + coord_t'(3);
                p.c[6] = p.c[2] + coord_t'(3); p.c[7] = p.c[3] + coord_t'(3);
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pair(seg_pair_t p);
        while ($urandom_range(0, 99) < send_idle)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        for (int i = 0; i < 8; i++)
            in_c[i] <= p.c[i];
        expected_q.push_back(closest_between(p));
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain_and_write(logic [CFG_W-1:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        deg_len_sq = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic seg_pair_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
        seg_pair_t p;
        p.c[0] = coord_t'(a); p.c[1] = coord_t'(b); p.c[2] = coord_t'(c);
        p.c[3] = coord_t'(d); p.c[4] = coord_t'(e); p.c[5] = coord_t'(f);
        p.c[6] = coord_t'(g); p.c[7] = coord_t'(h);
        return p;
    endfunction

    always @(posedge clk)
    begin
        closest_t e;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected beat dist_sq=%0d x=%0d y=%0d", $time,
                         dist_sq, closest_x, closest_y);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (dist_sq !== e.d)
                begin
                    $display("%0t: dist_sq expected %0d actual %0d", $time, e.d, dist_sq);
                    errors++;
                end
                if (closest_x !== e.x)
                begin
                    $display("%0t: closest_x expected %0d actual %0d", $time, e.x, closest_x);
                    errors++;
                end
                if (closest_y !== e.y)
                begin
                    $display("%0t: closest_y expected %0d actual %0d", $time, e.y, closest_y);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("segment_segment_distance_squared_unit test failed");
            $finish;
        end
    end

    initial
    begin
        dir_row_t dir_rows[$];
        dir_row_t r;
        seg_pair_t p;
        int nrand;
        errors = 0;
        cycles = 0;
        send_idle = 33;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        deg_len_sq = '0;
        for (int i = 0; i < 8; i++)
            in_c[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: known results where obvious, else predicted
        r = '{cfg: 0, cfg_val: 0, p: mk(0,0,0,0,0,0,0,0), known: 1, r: '{0, 0, 0}};
        dir_rows.push_back(r);
        r.p = mk(256,0,256,0,0,0,0,0); r.r = '{65536, 256, 0};
        dir_rows.push_back(r);
        r.p = mk(-512,0,512,0,0,-512,0,512); r.r = '{0, 0, 0};
        dir_rows.push_back(r);
        r.known = 0;
        r.p = mk(0,0,1024,0,0,256,1024,256); dir_rows.push_back(r);
        r.p = mk(0,0,1024,0,2048,0,3072,0); dir_rows.push_back(r);
        r.p = mk(0,0,1024,0,1024,0,1024,900); dir_rows.push_back(r);
        r.p = mk(0,0,1000,333,500,700,501,-7); dir_rows.push_back(r);
        r.p = mk(5,5,5,5,0,0,1000,0); dir_rows.push_back(r);
        r.p = mk(0,0,1000,7,300,300,300,300); dir_rows.push_back(r);
        r.p = mk(8388607,8388607,-8388608,-8388608,-8388608,8388607,8388607,-8388608);
        dir_rows.push_back(r);
        r.p = mk(8388607,8388607,8388607,8388607,-8388608,-8388608,-8388608,-8388608);
        dir_rows.push_back(r);
        r.p = mk(-8388608,8388607,8388607,8388607,-8388608,-8388608,8388607,-8388608);
        dir_rows.push_back(r);
        r.p = mk(0,0,3,1,100,100,103,101); dir_rows.push_back(r);
        r = '{cfg: 1, cfg_val: 16'hFFFF, p: mk(0,0,0,0,0,0,0,0), known: 0, r: '{0, 0, 0}};
        dir_rows.push_back(r);
        r.cfg = 0;
        r.p = mk(0,0,255,0,1000,1000,1000,1255); dir_rows.push_back(r);
        r.p = mk(0,0,256,0,10,10,10,10); dir_rows.push_back(r);
        r.p = mk(0,0,2000,0,500,500,500,600); dir_rows.push_back(r);
        r.p = mk(-8388608,-8388608,8388607,8388607,0,0,100,50); dir_rows.push_back(r);
        r.cfg = 1; r.cfg_val = 16'h5555; r.p = mk(0,0,100,100,0,100,100,0);
        dir_rows.push_back(r);
        r.cfg = 0; r.p = mk(0,0,120,0,60,60,60,-60); dir_rows.push_back(r);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg)
                drain_and_write(dir_rows[i].cfg_val);
            send_pair(dir_rows[i].p);
            if (dir_rows[i].known)
                expected_q[$] = dir_rows[i].r;
        end

        nrand = 0;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: drain_and_write(16'h0000);
                1: drain_and_write(16'h0100);
                2: drain_and_write(16'hFFFF);
                3: drain_and_write(16'(($urandom_range(0, 1) << 15) | $urandom_range(0, 32767)));
                4: drain_and_write(16'hAAAA);
                default: drain_and_write(16'h0001);
            endcase
            send_idle = phase < 2 ? 33 : (phase < 4 ? 79 : 0);
            repeat (205)
            begin
                p = rand_pair();
                send_pair(p);
                nrand++;
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        if (errors == 0)
            $display("segment_segment_distance_squared_unit test passed");
        else
            $display("segment_segment_distance_squared_unit test failed");
        $finish;
    end
endmodule
